// ===== rtl/cpf_pkg.sv =====
`default_nettype none
package cpf_pkg;

	localparam int TablePoints = 16;
	localparam int AngleBits = 16;
	localparam int AngleW = AngleBits;
	localparam int RadW = 24;
	localparam int PosW = 26;
	localparam int CountW = $clog2(TablePoints + 1);

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_SET = 2'd2;
	localparam logic [1:0] ACT_ADVANCE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_FEW = 2'd2;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;
	localparam logic [1:0] REG_VELOCITY = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [AngleW-1:0] angle_value;
		logic [RadW-1:0] radius_value;
		logic [15:0] time_step;
	} cmd_t;

	typedef struct packed {
		logic signed [PosW-1:0] follower_position;
		logic [AngleW-1:0] current_angle;
		logic [CountW-1:0] point_count;
		logic [1:0] status;
	} res_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic ins;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/cpf_cell.sv =====
`default_nettype none
module cpf_cell #(
	parameter int ABITS = 16
) (
	input wire clk,
	input wire cpf_pkg::cell_ctl_t ctl,
	input wire [ABITS-1:0] new_angle,
	input wire [cpf_pkg::RadW-1:0] new_radius,
	input wire live,
	input wire left_live,
	input wire left_gt,
	input wire [ABITS-1:0] left_angle,
	input wire [cpf_pkg::RadW-1:0] left_radius,
	input wire [ABITS-1:0] cam,
	output logic gt,
	output logic ge,
	output logic [ABITS-1:0] angle_q,
	output logic [cpf_pkg::RadW-1:0] radius_q
);
	import cpf_pkg::*;

	// entry is greater than new point: it shifts right
	assign gt = live && (angle_q > new_angle);
	assign ge = live && (angle_q >= cam);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (gt) begin
				if (left_live && left_gt) begin
					angle_q <= left_angle;
					radius_q <= left_radius;
				end else begin
					angle_q <= new_angle;
					radius_q <= new_radius;
				end
			end else if (!live) begin
				// first free slot
				if (left_live && left_gt) begin
					angle_q <= left_angle;
					radius_q <= left_radius;
				end else if (!left_live && left_gt) begin
					angle_q <= new_angle;
					radius_q <= new_radius;
				end else begin
					angle_q <= new_angle;
					radius_q <= new_radius;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cpf_div.sv =====
`default_nettype none
module cpf_div #(
	parameter int ABITS = 16
) (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire [cpf_pkg::RadW+ABITS-1:0] num,
	input wire [ABITS:0] den,
	output logic done,
	output logic [cpf_pkg::RadW+ABITS-1:0] quo_q
);
	import cpf_pkg::*;
	localparam int NW = RadW + ABITS;
	localparam int CW = $clog2(NW + 1);

	logic [ABITS+1:0] rem_q;
	logic [ABITS:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [ABITS+1:0] trial;
	logic [ABITS+1:0] sub;

	assign trial = {rem_q[ABITS:0], quo_q[NW-1]};
	assign sub = trial - {1'b0, den_q};
	assign done = busy_q && (cnt_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			if (!sub[ABITS+1]) begin
				rem_q <= sub;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cam_profile_follower_unit.sv =====
// cam profile follower
// cmd channel (cmd_valid/cmd_stall/cmd) takes one action: load a point,
// clear the table, set the cam angle or advance it by velocity * time_step.
// every action gives exactly one transfer on the result channel
// (res_valid/res_stall/res): follower position, angle, point count, status.
// the point table is a row of cells that shift right on a sorted insert,
// and each cell compares its angle with the cam angle in parallel.
// circular mode or too few points: the command passes the find and out
// states, and out loads the result register; table mode adds the prep
// state, the multiply stage and the bit-serial divider of the interpolation.
// one command is in work at a time; the next is taken the cycle after the
// result transfer.
// a stalled result holds the result register and blocks the command side.
// reset clears the angle, point count, registers and all handshake state;
// table contents are unknown until loaded.
// configuration must be written through the apb port only while idle;
// the block itself does not enforce this.
`default_nettype none
module cam_profile_follower_unit (
	input wire clk,
	input wire arst_n,
	input wire psel,
	input wire penable,
	input wire pwrite,
	input wire [3:0] paddr,
	input wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire cmd_valid,
	output logic cmd_stall,
	input wire cpf_pkg::cmd_t cmd,
	output logic res_valid,
	input wire res_stall,
	output cpf_pkg::res_t res
);
	import cpf_pkg::*;
	localparam int N = TablePoints;
	localparam int IW = $clog2(N);
	localparam int NCW = $clog2(N + 1);
	localparam int AB = AngleBits;
	localparam int NW = RadW + AB;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic mode_q;
	logic [RadW-1:0] crad_q;
	logic signed [RadW-1:0] offs_q;
	logic signed [15:0] vel_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			crad_q <= RadW'(256);
			offs_q <= '0;
			vel_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MODE: mode_q <= pwdata[0];
				REG_RADIUS: crad_q <= pwdata[RadW-1:0];
				REG_OFFSET: offs_q <= pwdata[RadW-1:0];
				REG_VELOCITY: vel_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			REG_MODE: prdata = {31'd0, mode_q};
			REG_RADIUS: prdata = {8'd0, crad_q};
			REG_OFFSET: prdata = {{8{offs_q[RadW-1]}}, offs_q};
			REG_VELOCITY: prdata = {{16{vel_q[15]}}, vel_q};
			default: prdata = '0;
		endcase
	end

	logic [2:0] state_q;
	logic [AB-1:0] cam_q;
	logic [NCW-1:0] cnt_q;
	logic [1:0] stat_q;
	logic res_full_q;
	res_t res_q;

	cell_ctl_t ctl;
	logic [AB-1:0] new_angle;
	logic [AB-1:0] cell_a [N];
	logic [RadW-1:0] cell_r [N];
	logic [N-1:0] gt_v, ge_v, live_v;

	logic take;
	assign cmd_stall = (state_q != S_IDLE) || res_full_q;
	assign take = cmd_valid && !cmd_stall;
	assign new_angle = cmd.angle_value[AB-1:0];
	assign ctl.ins = take && (cmd.action == ACT_LOAD) && (cnt_q < NCW'(N));

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			assign live_v[g] = NCW'(g) < cnt_q;
			if (g == 0) begin : g_first
				cpf_cell #(.ABITS(AB)) u_cell (
					.clk(clk), .ctl(ctl), .new_angle(new_angle),
					.new_radius(cmd.radius_value), .live(live_v[g]),
					.left_live(1'b0), .left_gt(1'b0),
					.left_angle(cell_a[g]), .left_radius(cell_r[g]),
					.cam(cam_q), .gt(gt_v[g]), .ge(ge_v[g]),
					.angle_q(cell_a[g]), .radius_q(cell_r[g]));
			end else begin : g_rest
				cpf_cell #(.ABITS(AB)) u_cell (
					.clk(clk), .ctl(ctl), .new_angle(new_angle),
					.new_radius(cmd.radius_value), .live(live_v[g]),
					.left_live(live_v[g-1]), .left_gt(gt_v[g-1]),
					.left_angle(cell_a[g-1]), .left_radius(cell_r[g-1]),
					.cam(cam_q), .gt(gt_v[g]), .ge(ge_v[g]),
					.angle_q(cell_a[g]), .radius_q(cell_r[g]));
			end
		end
	endgenerate

	// first live entry at or above cam angle, N when none (ge is a thermometer)
	logic [NCW-1:0] hit;
	always_comb begin
		hit = NCW'(N);
		for (int k = N - 1; k >= 0; k--)
			if (ge_v[k]) hit = NCW'(k);
	end

	logic [IW-1:0] lo_q, hi_q;
	logic [AB:0] span_q;
	logic [AB-1:0] dist_q;
	logic [AB-1:0] alo, ahi;
	logic [RadW-1:0] r0_q;
	logic neg_q;
	logic [RadW-1:0] mag_q;
	logic [RadW:0] rdiff;
	logic [AB-1:0] sp;
	assign alo = cell_a[lo_q];
	assign ahi = cell_a[hi_q];
	assign rdiff = {1'b0, cell_r[hi_q]} - {1'b0, cell_r[lo_q]};
	assign sp = ahi - alo;

	logic div_start, div_done;
	logic [NW-1:0] quo;
	logic [NW-1:0] prod_q;
	cpf_div #(.ABITS(AB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(prod_q), .den(span_q), .done(div_done), .quo_q(quo));

	// product is registered in the cycle after prep, divider starts the cycle after
	logic mul_go_q;
	logic prod_go_q;
	assign div_start = prod_go_q;

	logic signed [PosW-1:0] radius_w;
	logic signed [PosW-1:0] qs;
	assign qs = PosW'(quo);
	assign radius_w = neg_q ? ($signed({2'b00, r0_q}) - qs) : ($signed({2'b00, r0_q}) + qs);

	logic signed [AB+16:0] delta;
	assign delta = vel_q * $signed({1'b0, cmd.time_step});

	logic res_load;
	assign res_load = (state_q == S_OUT) && (!res_full_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cam_q <= '0;
			cnt_q <= '0;
			stat_q <= ST_OK;
			res_full_q <= 1'b0;
			mul_go_q <= 1'b0;
			prod_go_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			span_q <= '0;
			dist_q <= '0;
			r0_q <= '0;
			neg_q <= 1'b0;
			mag_q <= '0;
		end else begin
			if (res_load) res_full_q <= 1'b1;
			else if (!res_stall) res_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) begin
					stat_q <= ST_OK;
					case (cmd.action)
						ACT_LOAD: if (cnt_q < NCW'(N)) cnt_q <= cnt_q + 1'b1;
							else stat_q <= ST_FULL;
						ACT_CLEAR: cnt_q <= '0;
						ACT_SET: cam_q <= new_angle;
						default: cam_q <= cam_q + delta[AB-1:0];
					endcase
					state_q <= S_FIND;
				end
				S_FIND: begin
					if (!mode_q) state_q <= S_OUT;
					else if (cnt_q < NCW'(2)) begin
						if (stat_q == ST_OK) stat_q <= ST_FEW;
						state_q <= S_OUT;
					end else begin
						// no entry at or above the cam angle, or the first one is: wrap segment
						if (hit == NCW'(0) || hit >= cnt_q) begin
							lo_q <= IW'(cnt_q - 1'b1);
							hi_q <= '0;
						end else begin
							lo_q <= IW'(hit - 1'b1);
							hi_q <= IW'(hit);
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					span_q <= (sp == '0) ? {1'b1, {AB{1'b0}}} : {1'b0, sp};
					dist_q <= cam_q - alo;
					r0_q <= cell_r[lo_q];
					neg_q <= rdiff[RadW];
					mag_q <= rdiff[RadW] ? RadW'(-rdiff) : rdiff[RadW-1:0];
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) state_q <= S_OUT;
				end
				S_OUT: if (res_load) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			mul_go_q <= (state_q == S_PREP);
			prod_go_q <= mul_go_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= NW'(mag_q) * NW'(dist_q);
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.current_angle <= cam_q;
			res_q.point_count <= CountW'(cnt_q);
			res_q.status <= stat_q;
			if (!mode_q)
				res_q.follower_position <= $signed({2'b00, crad_q}) + PosW'(offs_q);
			else if (cnt_q < NCW'(2))
				res_q.follower_position <= PosW'(offs_q);
			else
				res_q.follower_position <= radius_w + PosW'(offs_q);
		end
	end

	assign res_valid = res_full_q;
	assign res = res_q;

	property p_one_busy;
		@(posedge clk) disable iff (!arst_n) take |=> state_q == S_FIND;
	endproperty
	a_one_busy: assert property (p_one_busy) else $error("take did not start work");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NCW'(N)) else $error("point count overflow");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !take) else $error("command taken while busy");
endmodule
`default_nettype wire
